>>> design/ers_pkg.sv
// ----------------------------------------------------------------------------
// ers_pkg
// Types, constants and codes shared by the elevator request scheduler files.
// ----------------------------------------------------------------------------
package ers_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  localparam int FLOOR_W = 6;
  localparam int CAP_W   = 5;
  localparam int SIZE_W  = 4;
  localparam int TIME_W  = 16;
  localparam int GCNT_W  = 7;
  localparam int COST_W  = 3;
  localparam int SUM_W   = 32;

  localparam logic [FLOOR_W-1:0] NUM_FLOORS_RESET   = 6'd10;
  localparam logic [CAP_W-1:0]   CAR_CAPACITY_RESET = 5'd10;
  localparam logic [FLOOR_W-1:0] FLOOR_BOTTOM       = 6'd1;
  localparam logic [FLOOR_W-1:0] MIN_TOP            = 6'd2;
  localparam logic [COST_W-1:0]  COST_OP            = 3'd2;
  localparam logic [COST_W-1:0]  COST_MOVE          = 3'd5;
  localparam logic [COST_W-1:0]  COST_IDLE          = 3'd1;

  // Command codes.
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_NUM_FLOORS   = 1'b0;
  localparam logic CFG_CAR_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED     = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_STEP      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_END,
    S_STEP_SCAN,
    S_STEP_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               command;
    logic [TIME_W-1:0]  now;
    logic [FLOOR_W-1:0] start_floor;
    logic [FLOOR_W-1:0] end_floor;
    logic [SIZE_W-1:0]  group_size;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [FLOOR_W-1:0] car_floor;
    logic               going_up;
    logic [CAP_W-1:0]   car_load;
    logic [GCNT_W-1:0]  groups_boarded;
    logic [GCNT_W-1:0]  groups_alighted;
    logic [COST_W-1:0]  time_cost;
    logic [TIME_W-1:0]  served_total;
    logic [SUM_W-1:0]   wait_sum;
    logic [SUM_W-1:0]   turnaround_sum;
  } result_t;

  // One request table entry, 51 bits.
  typedef struct packed {
    logic [FLOOR_W-1:0] start_floor;
    logic [FLOOR_W-1:0] end_floor;
    logic [SIZE_W-1:0]  group_size;
    logic [TIME_W-1:0]  called;
    logic [TIME_W-1:0]  picked;
    logic               up;
    logic               riding;
    logic               done;
  } entry_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] num_floors;
    logic [CAP_W-1:0]   car_capacity;
  } cfg_t;

  typedef struct packed {
    logic go;
    logic res_free;
  } core_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

>>> design/ers_in_if.sv
// ----------------------------------------------------------------------------
// ers_in_if
// Valid/ready channel that carries one input item of the scheduler.
// ----------------------------------------------------------------------------
interface ers_in_if import ers_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/ers_out_if.sv
// ----------------------------------------------------------------------------
// ers_out_if
// Valid/ready channel that carries one result item of the scheduler.
// ----------------------------------------------------------------------------
interface ers_out_if import ers_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/ers_core.sv
// ----------------------------------------------------------------------------
// ers_core
// Request table memory, car state and the sequencer that scans the table
// one entry per cycle for duplicate checks and for boarding and alighting.
// ----------------------------------------------------------------------------
module ers_core import ers_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  core_ctl_t  ctl,
  input  in_item_t   item_in,
  output core_stat_t stat,
  output result_t    result
);

  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(TABLE_DEPTH);

  entry_t mem [TABLE_DEPTH];

  state_t state, state_next;

  logic [COUNT_W-1:0] count, count_next;
  logic [COUNT_W-1:0] iss, iss_next;
  logic               pend;
  logic [ADDR_W-1:0]  proc_addr;

  logic [FLOOR_W-1:0] floor_now, floor_next;
  logic               heading_up, heading_next;
  logic [CAP_W-1:0]   riders, riders_next;
  logic [TIME_W-1:0]  served, served_next;
  logic [SUM_W-1:0]   wait_total, wait_next;
  logic [SUM_W-1:0]   trip_total, trip_next;

  in_item_t           item, item_load;
  status_t            status_r, status_next;
  logic [GCNT_W-1:0]  boarded, boarded_next;
  logic [GCNT_W-1:0]  alighted, alighted_next;
  logic [COST_W-1:0]  cost, cost_next;
  logic               dup, dup_next;
  logic               op_any, op_next;
  logic               open_any, open_next;
  logic               wait_above, wait_above_next;
  logic               wait_below, wait_below_next;
  logic               ride_up, ride_up_next;
  logic               ride_down, ride_down_next;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  entry_t             rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;
  logic               core_done;

  // Per-entry evaluation for the step scan.
  entry_t                   e, e_new;
  logic                     board_hit, board_ok, board, alight;
  logic [CAP_W:0]           load_sum;
  logic [CAP_W-1:0]         r1, r2;
  logic [TIME_W-1:0]        w_diff, t_diff;
  logic [TIME_W+SIZE_W-1:0] w_prod, t_prod;
  logic [SUM_W:0]           w_sum, t_sum;
  logic [TIME_W:0]          s_sum;
  logic                     match;

  // Move decision.
  logic [FLOOR_W-1:0]       top;
  logic                     pick_up, move_up;

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_addr = iss[ADDR_W-1:0];
  assign e       = rd_data;

  assign match = (e.start_floor == item.start_floor) && (e.end_floor == item.end_floor) &&
                 (e.called == item.now);

  always_comb begin
    board_hit = (e.start_floor == floor_now) && !e.riding && !e.done;
    load_sum  = {2'b00, e.group_size} + {1'b0, riders};
    if (riders != '0) begin
      board_ok = (e.up == heading_up) && (load_sum <= {1'b0, cfg.car_capacity});
    end else begin
      board_ok = 1'b1;
    end
    board = board_hit && board_ok;
    r1    = board ? load_sum[CAP_W-1:0] : riders;

    e_new        = e;
    e_new.riding = e.riding | board;
    e_new.picked = board ? item.now : e.picked;

    // A group that boards here may leave at once when its end is this floor.
    alight = (e.end_floor == floor_now) && e_new.riding && !e.done &&
             (r1 >= {1'b0, e.group_size});
    r2     = alight ? (r1 - {1'b0, e.group_size}) : r1;
    e_new.done   = e.done | alight;
    e_new.riding = e_new.riding & !alight;

    w_diff = e_new.picked - e.called;
    t_diff = item.now - e.called;
    w_prod = w_diff * e.group_size;
    t_prod = t_diff * e.group_size;
    w_sum  = {1'b0, wait_total} + {{(SUM_W+1-TIME_W-SIZE_W){1'b0}}, w_prod};
    t_sum  = {1'b0, trip_total} + {{(SUM_W+1-TIME_W-SIZE_W){1'b0}}, t_prod};
    s_sum  = {1'b0, served} + {{(TIME_W+1-SIZE_W){1'b0}}, e.group_size};
  end

  always_comb begin
    top = (cfg.num_floors < MIN_TOP) ? MIN_TOP : cfg.num_floors;
    if (!heading_up) begin
      if (floor_now <= FLOOR_BOTTOM) begin
        pick_up = 1'b1;
      end else begin
        pick_up = !(wait_below || ride_down);
      end
    end else begin
      if (({1'b0, floor_now} + 7'd1) > {1'b0, top}) begin
        pick_up = 1'b0;
      end else begin
        pick_up = wait_above || ride_up;
      end
    end
    if (pick_up && (floor_now >= top)) begin
      move_up = 1'b0;
    end else if (!pick_up && (floor_now <= FLOOR_BOTTOM)) begin
      move_up = 1'b1;
    end else begin
      move_up = pick_up;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    iss_next        = iss;
    floor_next      = floor_now;
    heading_next    = heading_up;
    riders_next     = riders;
    served_next     = served;
    wait_next       = wait_total;
    trip_next       = trip_total;
    item_load       = item;
    status_next     = status_r;
    boarded_next    = boarded;
    alighted_next   = alighted;
    cost_next       = cost;
    dup_next        = dup;
    op_next         = op_any;
    open_next       = open_any;
    wait_above_next = wait_above;
    wait_below_next = wait_below;
    ride_up_next    = ride_up;
    ride_down_next  = ride_down;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = proc_addr;
    wr_data         = e_new;
    core_done       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (ctl.go) begin
          item_load       = item_in;
          iss_next        = '0;
          dup_next        = 1'b0;
          op_next         = 1'b0;
          open_next       = 1'b0;
          wait_above_next = 1'b0;
          wait_below_next = 1'b0;
          ride_up_next    = 1'b0;
          ride_down_next  = 1'b0;
          boarded_next    = '0;
          alighted_next   = '0;
          cost_next       = '0;
          state_next      = (item_in.command == CMD_ADD) ? S_ADD_SCAN : S_STEP_SCAN;
        end
      end
      S_ADD_SCAN: begin
        if (iss != count) begin
          rd_en    = 1'b1;
          iss_next = iss + 1'b1;
        end
        if (pend && match) begin
          dup_next = 1'b1;
        end
        if ((iss == count) && !pend) begin
          state_next = S_ADD_END;
        end
      end
      S_ADD_END: begin
        if (dup) begin
          status_next = ST_DUPLICATE;
        end else if (count >= DEPTH_COUNT) begin
          status_next = ST_FULL;
        end else begin
          status_next         = ST_ADDED;
          wr_en               = 1'b1;
          wr_addr             = count[ADDR_W-1:0];
          wr_data.start_floor = item.start_floor;
          wr_data.end_floor   = item.end_floor;
          wr_data.group_size  = item.group_size;
          wr_data.called      = item.now;
          wr_data.picked      = '0;
          wr_data.up          = item.end_floor > item.start_floor;
          wr_data.riding      = 1'b0;
          wr_data.done        = 1'b0;
          count_next          = count + 1'b1;
        end
        state_next = S_DONE;
      end
      S_STEP_SCAN: begin
        if (iss != count) begin
          rd_en    = 1'b1;
          iss_next = iss + 1'b1;
        end
        if (pend) begin
          wr_en           = board || alight;
          riders_next     = r2;
          boarded_next    = boarded + {{(GCNT_W-1){1'b0}}, board};
          alighted_next   = alighted + {{(GCNT_W-1){1'b0}}, alight};
          op_next         = op_any || board || alight;
          open_next       = open_any || !e_new.done || e_new.riding;
          wait_above_next = wait_above ||
                            (!e_new.done && !e_new.riding && (e.start_floor > floor_now));
          wait_below_next = wait_below ||
                            (!e_new.done && !e_new.riding && (e.start_floor < floor_now));
          ride_up_next    = ride_up || (e_new.riding && e.up);
          ride_down_next  = ride_down || (e_new.riding && !e.up);
          if (alight) begin
            served_next = s_sum[TIME_W] ? '1 : s_sum[TIME_W-1:0];
            wait_next   = w_sum[SUM_W] ? '1 : w_sum[SUM_W-1:0];
            trip_next   = t_sum[SUM_W] ? '1 : t_sum[SUM_W-1:0];
          end
        end
        if ((iss == count) && !pend) begin
          state_next = S_STEP_END;
        end
      end
      S_STEP_END: begin
        status_next = ST_STEP;
        if (open_any) begin
          heading_next = move_up;
          floor_next   = move_up ? (floor_now + 1'b1) : (floor_now - 1'b1);
          cost_next    = (op_any ? COST_OP : '0) + COST_MOVE;
        end else begin
          cost_next    = (op_any ? COST_OP : '0) + COST_IDLE;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (ctl.res_free) begin
          core_done  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend       <= 1'b0;
      floor_now  <= FLOOR_BOTTOM;
      heading_up <= 1'b1;
      riders     <= '0;
      served     <= '0;
      wait_total <= '0;
      trip_total <= '0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend       <= rd_en;
      floor_now  <= floor_next;
      heading_up <= heading_next;
      riders     <= riders_next;
      served     <= served_next;
      wait_total <= wait_next;
      trip_total <= trip_next;
    end
  end

  always_ff @(posedge clk) begin
    iss        <= iss_next;
    proc_addr  <= rd_addr;
    item       <= item_load;
    status_r   <= status_next;
    boarded    <= boarded_next;
    alighted   <= alighted_next;
    cost       <= cost_next;
    dup        <= dup_next;
    op_any     <= op_next;
    open_any   <= open_next;
    wait_above <= wait_above_next;
    wait_below <= wait_below_next;
    ride_up    <= ride_up_next;
    ride_down  <= ride_down_next;
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = core_done;

  always_comb begin
    result.status          = status_r;
    result.car_floor       = floor_now;
    result.going_up        = heading_up;
    result.car_load        = riders;
    result.groups_boarded  = boarded;
    result.groups_alighted = alighted;
    result.time_cost       = cost;
    result.served_total    = served;
    result.wait_sum        = wait_total;
    result.turnaround_sum  = trip_total;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_COUNT)
    else $error("request table count beyond depth");

  a_floor_nonzero: assert property (@(posedge clk) disable iff (rst)
    floor_now != '0)
    else $error("car reached floor zero");

  a_go_when_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.go |-> (state == S_IDLE))
    else $error("item started while busy");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !rst |=> ((count == $past(count)) || (count == $past(count) + 1'b1)))
    else $error("table count moved by more than one");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (((state == S_STEP_SCAN) && pend) || (state == S_ADD_END)))
    else $error("table written outside a scan or append");
`endif

endmodule

>>> design/elevator_request_scheduler.sv
// ----------------------------------------------------------------------------
// elevator_request_scheduler
// One elevator car serving a table of call requests with LOOK direction rules.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_ch (valid/ready). An add item appends a call
// request after a duplicate check and a full-table check; a step item boards
// and drops groups at the car's floor and then moves the car one floor or
// idles. Each item yields exactly one result item on out_ch (valid/ready).
// Configuration is written through cfg_write/cfg_index/cfg_data while the
// block is idle: index 0 sets the top floor, index 1 the car capacity.
// Each item scans every table entry; the table memory is read one entry
// per cycle, and a full table holds 64 entries.
// One item is worked on at a time; in_ch.ready is high while the sequencer
// is idle and rst is low. The result register lets the next item be
// accepted while the last result still waits on out_ch. If the receiver
// stalls with a result pending, a finished item waits in the sequencer
// until the register frees.
// Reset (rst, synchronous) empties the table, puts the car at floor 1 going
// up and empty, clears the sums, and restores both configuration registers.
// ----------------------------------------------------------------------------
module elevator_request_scheduler import ers_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [FLOOR_W-1:0] cfg_data,
  ers_in_if.sink             in_ch,
  ers_out_if.source          out_ch
);

  cfg_t       cfg;
  core_ctl_t  ctl;
  core_stat_t stat;
  result_t    result;
  logic       out_valid;
  result_t    out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_floors   <= NUM_FLOORS_RESET;
      cfg.car_capacity <= CAR_CAPACITY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_NUM_FLOORS:   cfg.num_floors   <= cfg_data;
        CFG_CAR_CAPACITY: cfg.car_capacity <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready  = stat.idle && !rst;
  assign ctl.go       = in_ch.valid && stat.idle && !rst;
  assign ctl.res_free = !out_valid || out_ch.ready;

  ers_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .ctl     (ctl),
    .item_in (in_ch.data),
    .stat    (stat),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_data <= result;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the elevator request scheduler. A directed list of
// call requests and steps is followed by random traffic over several floor
// and capacity settings. Every result item is checked field by field against
// a behavioral scheduler model in the bench, or the typed result of a pinned row.
// ----------------------------------------------------------------------------
module tb_top;
  import ers_pkg::*;

  localparam int      PHASES      = 8;
  localparam int      PHASE_ITEMS = 156;
  localparam result_t NO_RESULT   = '0;

  typedef struct packed {
    logic     pinned;
    in_item_t item;
    result_t  want;
  } plan_row_t;

  // Pinned rows carry the result typed in; the others are predicted.
  localparam plan_row_t DIRECTED_PLAN [24] = '{
    {1'b1, CMD_STEP, 16'd0, 6'd1, 6'd1, 4'd1,
     ST_STEP, 6'd1, 1'b1, 5'd0, 7'd0, 7'd0, COST_IDLE, 16'd0, 32'd0, 32'd0},
    {1'b1, CMD_ADD, 16'd0, 6'd1, 6'd1, 4'd15,
     ST_ADDED, 6'd1, 1'b1, 5'd0, 7'd0, 7'd0, 3'd0, 16'd0, 32'd0, 32'd0},
    {1'b1, CMD_ADD, 16'd0, 6'd1, 6'd1, 4'd15,
     ST_DUPLICATE, 6'd1, 1'b1, 5'd0, 7'd0, 7'd0, 3'd0, 16'd0, 32'd0, 32'd0},
    {1'b0, CMD_STEP, 16'd4, 6'd1, 6'd1, 4'd1, NO_RESULT},
    {1'b0, CMD_ADD, 16'd65535, 6'd2, 6'd5, 4'd15, NO_RESULT},
    {1'b0, CMD_ADD, 16'd65535, 6'd2, 6'd3, 4'd1, NO_RESULT},
    {1'b0, CMD_ADD, 16'd65535, 6'd5, 6'd2, 4'd1, NO_RESULT},
    {1'b0, CMD_ADD, 16'd100, 6'd63, 6'd63, 4'd8, NO_RESULT},
    {1'b0, CMD_ADD, 16'd21845, 6'd42, 6'd21, 4'd5, NO_RESULT},
    {1'b0, CMD_ADD, 16'd43690, 6'd1, 6'd63, 4'd7, NO_RESULT},
    {1'b0, CMD_STEP, 16'd2, 6'd63, 6'd63, 4'd15, NO_RESULT},
    {1'b0, CMD_STEP, 16'd9, 6'd1, 6'd1, 4'd1, NO_RESULT},
    {1'b0, CMD_STEP, 16'd16, 6'd21, 6'd42, 4'd10, NO_RESULT},
    {1'b0, CMD_STEP, 16'd23, 6'd42, 6'd21, 4'd5, NO_RESULT},
    {1'b0, CMD_STEP, 16'd30, 6'd1, 6'd1, 4'd1, NO_RESULT},
    {1'b0, CMD_STEP, 16'd37, 6'd1, 6'd1, 4'd1, NO_RESULT},
    {1'b0, CMD_STEP, 16'd44, 6'd1, 6'd1, 4'd1, NO_RESULT},
    {1'b0, CMD_STEP, 16'd51, 6'd1, 6'd1, 4'd1, NO_RESULT},
    {1'b0, CMD_STEP, 16'd58, 6'd1, 6'd1, 4'd1, NO_RESULT},
    {1'b0, CMD_STEP, 16'd65, 6'd1, 6'd1, 4'd1, NO_RESULT},
    {1'b0, CMD_STEP, 16'd72, 6'd1, 6'd1, 4'd1, NO_RESULT},
    {1'b0, CMD_ADD, 16'd65535, 6'd2, 6'd5, 4'd3, NO_RESULT},
    {1'b0, CMD_STEP, 16'd80, 6'd1, 6'd1, 4'd1, NO_RESULT},
    {1'b0, CMD_STEP, 16'd65535, 6'd1, 6'd1, 4'd1, NO_RESULT}
  };

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic               cfg_index;
  logic [FLOOR_W-1:0] cfg_data;

  ers_in_if  in_ch ();
  ers_out_if out_ch ();

  elevator_request_scheduler DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Scheduler model state.
  entry_t             call_log [TABLE_DEPTH];
  int unsigned        call_total;
  logic [FLOOR_W-1:0] car_at;
  logic               car_rising;
  logic [CAP_W-1:0]   car_riders;
  logic [TIME_W-1:0]  delivered;
  logic [SUM_W-1:0]   wait_acc;
  logic [SUM_W-1:0]   trip_acc;
  logic [FLOOR_W-1:0] top_setting;
  logic [CAP_W-1:0]   cap_setting;

  result_t     awaited_results [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned burst_left;
  bit          steady_sender;

  task automatic flag_mismatch(input string what, input logic [SUM_W-1:0] got,
                               input logic [SUM_W-1:0] want);
    $display("ERROR result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic logic [SUM_W-1:0] add_capped(input logic [SUM_W-1:0] acc,
                                                   input longint unsigned extra);
    longint unsigned total;
    total = 64'(acc) + extra;
    return (total > 64'hFFFF_FFFF) ? '1 : SUM_W'(total);
  endfunction

  function automatic bit waiting_past(input bit above);
    int i;
    for (i = 0; i < int'(call_total); i++)
      if (!call_log[i].done && !call_log[i].riding &&
          (above ? call_log[i].start_floor > car_at : call_log[i].start_floor < car_at))
        return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit riders_bound(input bit up);
    int i;
    for (i = 0; i < int'(call_total); i++)
      if (call_log[i].riding && call_log[i].up == up)
        return 1'b1;
    return 1'b0;
  endfunction

  // Applies one item to the model and returns the result it should produce.
  function automatic result_t schedule(input in_item_t it);
    result_t           r;
    int                i;
    int                top;
    int unsigned       boarded, alighted, cost, total;
    bit                clash, busy, fits, go_up;
    logic [TIME_W-1:0] waited, spent;
    r = '0;
    boarded = 0;
    alighted = 0;
    cost = 0;
    if (it.command == CMD_ADD) begin
      clash = 1'b0;
      for (i = 0; i < int'(call_total); i++)
        if (call_log[i].start_floor == it.start_floor &&
            call_log[i].end_floor == it.end_floor && call_log[i].called == it.now)
          clash = 1'b1;
      if (clash) begin
        r.status = ST_DUPLICATE;
      end else if (call_total >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        call_log[call_total] = {it.start_floor, it.end_floor, it.group_size, it.now,
                                16'd0, it.end_floor > it.start_floor, 1'b0, 1'b0};
        call_total++;
        r.status = ST_ADDED;
      end
    end else begin
      r.status = ST_STEP;
      top = (top_setting < MIN_TOP) ? int'(MIN_TOP) : int'(top_setting);
      busy = 1'b0;
      for (i = 0; i < int'(call_total); i++) begin
        if (call_log[i].start_floor == car_at && !call_log[i].riding && !call_log[i].done) begin
          // An empty car takes any group; otherwise direction and room must match.
          fits = (car_riders == 0) ||
                 (call_log[i].up == car_rising &&
                  int'(car_riders) + int'(call_log[i].group_size) <= int'(cap_setting));
          if (fits) begin
            car_riders = car_riders + CAP_W'(call_log[i].group_size);
            call_log[i].picked = it.now;
            call_log[i].riding = 1'b1;
            boarded++;
            busy = 1'b1;
          end
        end
        if (call_log[i].end_floor == car_at && call_log[i].riding && !call_log[i].done &&
            car_riders >= call_log[i].group_size) begin
          waited = call_log[i].picked - call_log[i].called;
          spent = it.now - call_log[i].called;
          car_riders = car_riders - CAP_W'(call_log[i].group_size);
          call_log[i].done = 1'b1;
          call_log[i].riding = 1'b0;
          total = 32'(delivered) + 32'(call_log[i].group_size);
          delivered = (total > 32'hFFFF) ? 16'hFFFF : TIME_W'(total);
          wait_acc = add_capped(wait_acc, 64'(waited) * call_log[i].group_size);
          trip_acc = add_capped(trip_acc, 64'(spent) * call_log[i].group_size);
          alighted++;
          busy = 1'b1;
        end
      end
      if (busy)
        cost += COST_OP;
      busy = 1'b0;
      for (i = 0; i < int'(call_total); i++)
        if (!call_log[i].done || call_log[i].riding)
          busy = 1'b1;
      if (busy) begin
        if (!car_rising)
          go_up = (car_at <= FLOOR_BOTTOM) ? 1'b1 : !(waiting_past(1'b0) || riders_bound(1'b0));
        else
          go_up = (int'(car_at) + 1 > top) ? 1'b0 : (waiting_past(1'b1) || riders_bound(1'b1));
        if (go_up && int'(car_at) >= top)
          go_up = 1'b0;
        else if (!go_up && car_at <= FLOOR_BOTTOM)
          go_up = 1'b1;
        car_rising = go_up;
        car_at = go_up ? car_at + 1'b1 : car_at - 1'b1;
        cost += COST_MOVE;
      end else begin
        cost += COST_IDLE;
      end
    end
    r.car_floor = car_at;
    r.going_up = car_rising;
    r.car_load = car_riders;
    r.groups_boarded = GCNT_W'(boarded);
    r.groups_alighted = GCNT_W'(alighted);
    r.time_cost = COST_W'(cost);
    r.served_total = delivered;
    r.wait_sum = wait_acc;
    r.turnaround_sum = trip_acc;
    return r;
  endfunction

  // Offers one item in the current burst and records its expected result.
  task automatic offer(input in_item_t it, input logic pinned, input result_t want);
    result_t predicted;
    int      gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(6, 0);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    predicted = schedule(it);
    awaited_results.push_back(pinned ? want : predicted);
  endtask

  // Registers change only with the block idle and every result collected.
  task automatic set_limits(input logic [FLOOR_W-1:0] top, input logic [CAP_W-1:0] cap);
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_NUM_FLOORS;
    cfg_data <= top;
    @(posedge clk);
    cfg_index <= CFG_CAR_CAPACITY;
    cfg_data <= FLOOR_W'(cap);
    @(posedge clk);
    cfg_write <= 1'b0;
    top_setting = top;
    cap_setting = cap;
    burst_left = 0;
  endtask

  initial begin : stimulus
    in_item_t           it;
    in_item_t           pick;
    in_item_t           placed_calls [$];
    logic [TIME_W-1:0]  clock_now;
    logic [FLOOR_W-1:0] reach;
    int                 phase, n;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_NUM_FLOORS;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    call_total = 0;
    car_at = FLOOR_BOTTOM;
    car_rising = 1'b1;
    car_riders = '0;
    delivered = '0;
    wait_acc = '0;
    trip_acc = '0;
    top_setting = NUM_FLOORS_RESET;
    cap_setting = CAR_CAPACITY_RESET;
    mismatches = 0;
    burst_left = 0;
    steady_sender = 1'b0;
    clock_now = 16'd100;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_PLAN[k])
      offer(DIRECTED_PLAN[k].item, DIRECTED_PLAN[k].pinned, DIRECTED_PLAN[k].want);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_limits(MIN_TOP, 5'd1);
        1: set_limits(6'd63, 5'd16);
        2: set_limits(6'd1, 5'($urandom_range(16, 1)));
        PHASES - 1: set_limits(6'd63, 5'd16);
        default: set_limits(6'($urandom_range(63, 2)), 5'($urandom_range(16, 1)));
      endcase
      steady_sender = (phase == 1 || phase == 5);
      reach = (top_setting < MIN_TOP) ? MIN_TOP : top_setting;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // A mostly steady clock with an occasional jump anywhere in its range.
        if ($urandom_range(49, 0) == 0)
          clock_now = 16'($urandom);
        else
          clock_now = clock_now + 16'($urandom_range(7, 1));
        it.command = CMD_STEP;
        it.now = clock_now;
        it.start_floor = 6'($urandom_range(63, 1));
        it.end_floor = 6'($urandom_range(63, 1));
        it.group_size = 4'($urandom_range(15, 1));
        if ($urandom_range(99, 0) < 8) begin
          it.command = CMD_ADD;
          if (placed_calls.size() != 0 && $urandom_range(5, 0) == 0) begin
            pick = placed_calls[$urandom_range(placed_calls.size() - 1, 0)];
            it.start_floor = pick.start_floor;
            it.end_floor = pick.end_floor;
            it.now = pick.now;
          end else if ($urandom_range(6, 0) != 0) begin
            it.start_floor = 6'($urandom_range(reach, 1));
            it.end_floor = 6'($urandom_range(reach, 1));
          end
          placed_calls.push_back(it);
        end
        offer(it, 1'b0, NO_RESULT);
      end
    end

    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Receiver: ready follows one of four patterns picked anew at random,
  // with one long hold-off so that the block backs up into its input.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned cycle_cnt;
    int          mode;
    bit          held;
    hold_left = 0;
    cycle_cnt = 0;
    mode = 0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt % 48 == 0)
        mode = $urandom_range(3, 0);
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        hold_left = 700;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(1, 0));
          2: out_ch.ready <= (cycle_cnt % 4 != 3);
          default: out_ch.ready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_seen <= results_seen + 1;
      if (awaited_results.size() == 0) begin
        flag_mismatch("result with none expected, status", got.status, '0);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status)
          flag_mismatch("status", got.status, want.status);
        if (got.car_floor !== want.car_floor)
          flag_mismatch("car_floor", got.car_floor, want.car_floor);
        if (got.going_up !== want.going_up)
          flag_mismatch("going_up", got.going_up, want.going_up);
        if (got.car_load !== want.car_load)
          flag_mismatch("car_load", got.car_load, want.car_load);
        if (got.groups_boarded !== want.groups_boarded)
          flag_mismatch("groups_boarded", got.groups_boarded, want.groups_boarded);
        if (got.groups_alighted !== want.groups_alighted)
          flag_mismatch("groups_alighted", got.groups_alighted, want.groups_alighted);
        if (got.time_cost !== want.time_cost)
          flag_mismatch("time_cost", got.time_cost, want.time_cost);
        if (got.served_total !== want.served_total)
          flag_mismatch("served_total", got.served_total, want.served_total);
        if (got.wait_sum !== want.wait_sum)
          flag_mismatch("wait_sum", got.wait_sum, want.wait_sum);
        if (got.turnaround_sum !== want.turnaround_sum)
          flag_mismatch("turnaround_sum", got.turnaround_sum, want.turnaround_sum);
      end
    end
  end

  initial results_seen = 0;

  initial begin : watchdog
    #15ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
